// ===== rtl/bpa_pkg.sv =====
// Buddy page allocator: shared constants, types and helpers.
// No dependencies.
package bpa_pkg;
	localparam int NUM_PAGES_DEF   = 4096;
	localparam int ORDER_COUNT_DEF = 11;
	localparam int PFN_W   = 20;
	localparam int PAGES_W = 13;
	localparam int ORD_W   = 4;
	localparam int STAT_W  = 2;
	localparam int CNT_W   = 16;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FAIL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic CFG_BASE = 1'b0;
	localparam logic CFG_LAST = 1'b1;

	// controller to datapath commands
	localparam logic [3:0] OP_NONE  = 4'd0;
	localparam logic [3:0] OP_WNEXT = 4'd2;
	localparam logic [3:0] OP_WPREV = 4'd3;
	localparam logic [3:0] OP_WBOTH = 4'd4;
	localparam logic [3:0] OP_HEAD  = 4'd5;
	localparam logic [3:0] OP_INC   = 4'd6;
	localparam logic [3:0] OP_DEC   = 4'd7;
	localparam logic [3:0] OP_PAIRR = 4'd8;
	localparam logic [3:0] OP_PAIRW = 4'd9;
	localparam logic [3:0] OP_INIT  = 4'd10;
	localparam logic [3:0] OP_PINIT = 4'd12;

	typedef struct packed {
		logic             func;
		logic [PAGES_W-1:0] request_pages;
		logic [PFN_W-1:0] block_page;
		logic             is_null;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [PFN_W-1:0]  granted_page;
		logic [ORD_W-1:0]  granted_order;
	} rsp_t;

	// order of a page count, rounded up; 0 and 1 give 0
	function automatic logic [ORD_W:0] order_of(input logic [PAGES_W-1:0] p);
		logic [PAGES_W-1:0] v;
		logic [ORD_W:0] o;
		v = p - 1'b1;
		o = '0;
		if (p > 1) begin
			for (int i = 0; i < PAGES_W; i++) begin
				if (v[i]) o = (ORD_W+1)'(i + 1);
			end
		end
		return o;
	endfunction
endpackage

// ===== rtl/bpa_if.sv =====
// Valid/ready channel interfaces for the allocator.
// Depends on bpa_pkg.
interface bpa_req_if;
	logic valid;
	logic ready;
	bpa_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bpa_rsp_if;
	logic valid;
	logic ready;
	bpa_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bpa_cfg_if;
	logic valid;
	logic ready;
	logic index;
	logic [bpa_pkg::PFN_W-1:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/bpa_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// ===== rtl/bpa_datapath.sv =====
// Allocator datapath: link memories, pair-bit memory, heads, counters.
// Depends on bpa_pkg and bpa_ram; driven by bpa_ctrl commands.
module bpa_datapath #(
	parameter int NUM_PAGES   = bpa_pkg::NUM_PAGES_DEF,
	parameter int ORDER_COUNT = bpa_pkg::ORDER_COUNT_DEF,
	localparam int IW = $clog2(NUM_PAGES) + 1,
	localparam int AW = $clog2(NUM_PAGES),
	localparam int OW = (ORDER_COUNT > 1) ? $clog2(ORDER_COUNT) : 1,
	localparam int PW = $clog2(NUM_PAGES * ORDER_COUNT)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [3:0]    op,
	input  logic [IW-1:0] a_idx,
	input  logic [IW-1:0] b_idx,
	input  logic [OW-1:0] ord,
	input  logic [AW-1:0] init_addr,
	output logic [IW-1:0] next_rd,
	output logic [IW-1:0] prev_rd,
	output logic          pair_rd,
	output logic [IW-1:0] head_rd,
	output logic          lvl_empty
);
	import bpa_pkg::*;

	localparam int TOP   = ORDER_COUNT - 1;
	localparam int SZ    = 1 << TOP;
	localparam int TCNT  = NUM_PAGES / SZ;
	localparam logic [IW-1:0] NIL = IW'(NUM_PAGES);

	logic [IW-1:0]    head_q [ORDER_COUNT];
	logic [CNT_W-1:0] cnt_q  [ORDER_COUNT];

	logic          n_we, p_we, b_we;
	logic [IW-1:0] n_wd, p_wd;
	logic          b_wd;
	logic [AW-1:0] lk_addr;
	logic [PW-1:0] b_addr;
	logic [IW-1:0] init_n, init_p;
	logic [IW:0]   ia;

	assign ia = {1'b0, 1'b0, init_addr};
	always_comb begin
		init_p = ((ia >> TOP) == 0) ? NIL : IW'(ia - (IW+1)'(SZ));
		init_n = ((ia >> TOP) + 1 < (IW+1)'(TCNT)) ? IW'(ia + (IW+1)'(SZ)) : NIL;
		if (init_addr[((TOP > 0) ? TOP : 1)-1:0] != 0 && TOP > 0) begin
			init_p = NIL;
			init_n = NIL;
		end
	end

	always_comb begin
		n_we = 1'b0;
		p_we = 1'b0;
		b_we = 1'b0;
		n_wd = b_idx;
		p_wd = b_idx;
		b_wd = ~pair_rd;
		lk_addr = a_idx[AW-1:0];
		b_addr = PW'(ord) * PW'(NUM_PAGES) + PW'(a_idx[AW-1:0]);
		case (op)
			OP_WNEXT: n_we = 1'b1;
			OP_WPREV: p_we = 1'b1;
			OP_WBOTH: begin
				n_we = 1'b1;
				p_we = 1'b1;
				n_wd = NIL;
				p_wd = NIL;
			end
			OP_PAIRW: b_we = 1'b1;
			OP_INIT: begin
				n_we = 1'b1;
				p_we = 1'b1;
				n_wd = init_n;
				p_wd = init_p;
				lk_addr = init_addr;
			end
			OP_PINIT: begin
				b_we = 1'b1;
				b_wd = 1'b0;
				b_addr = PW'(ord) * PW'(NUM_PAGES) + PW'(init_addr);
			end
			default: ;
		endcase
	end

	bpa_ram #(.WIDTH(IW), .DEPTH(NUM_PAGES)) u_next (
		.clk(clk), .we(n_we), .addr(lk_addr), .wdata(n_wd), .rdata(next_rd));
	bpa_ram #(.WIDTH(IW), .DEPTH(NUM_PAGES)) u_prev (
		.clk(clk), .we(p_we), .addr(lk_addr), .wdata(p_wd), .rdata(prev_rd));
	bpa_ram #(.WIDTH(1), .DEPTH(NUM_PAGES * ORDER_COUNT)) u_pair (
		.clk(clk), .we(b_we), .addr(b_addr), .wdata(b_wd), .rdata(pair_rd));

	assign head_rd = head_q[ord];
	assign lvl_empty = (cnt_q[ord] == 0) || (head_q[ord] >= NIL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ORDER_COUNT; i++) begin
				head_q[i] <= (i == TOP && TCNT > 0) ? '0 : NIL;
				cnt_q[i]  <= (i == TOP) ? CNT_W'(TCNT) : '0;
			end
		end else begin
			case (op)
				OP_HEAD: head_q[ord] <= b_idx;
				OP_INC: if (cnt_q[ord] != '1) cnt_q[ord] <= cnt_q[ord] + 1'b1;
				OP_DEC: if (cnt_q[ord] != '0) cnt_q[ord] <= cnt_q[ord] - 1'b1;
				default: ;
			endcase
		end
	end
endmodule

// ===== rtl/bpa_ctrl.sv =====
// Allocator controller: sequences alloc, free and the clearing pass.
// Depends on bpa_pkg; commands bpa_datapath.
module bpa_ctrl #(
	parameter int NUM_PAGES   = bpa_pkg::NUM_PAGES_DEF,
	parameter int ORDER_COUNT = bpa_pkg::ORDER_COUNT_DEF,
	localparam int IW = $clog2(NUM_PAGES) + 1,
	localparam int AW = $clog2(NUM_PAGES),
	localparam int OW = (ORDER_COUNT > 1) ? $clog2(ORDER_COUNT) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  bpa_pkg::req_t        in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output bpa_pkg::rsp_t        out_data,
	input  logic [bpa_pkg::PFN_W-1:0] base_page,
	input  logic [bpa_pkg::PFN_W-1:0] last_page,
	output logic [3:0]           op,
	output logic [IW-1:0]        a_idx,
	output logic [IW-1:0]        b_idx,
	output logic [OW-1:0]        ord,
	output logic [AW-1:0]        init_addr,
	input  logic [IW-1:0]        next_rd,
	input  logic [IW-1:0]        prev_rd,
	input  logic                 pair_rd,
	input  logic [IW-1:0]        head_rd,
	input  logic                 lvl_empty
);
	import bpa_pkg::*;

	localparam logic [IW-1:0] NIL = IW'(NUM_PAGES);

	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_DECODE= 5'd2;
	localparam logic [4:0] S_SCAN  = 5'd3;
	localparam logic [4:0] S_U0    = 5'd4;  // unlink: read links
	localparam logic [4:0] S_U1    = 5'd5;  // latch p, n
	localparam logic [4:0] S_U2    = 5'd6;  // next[p] or head
	localparam logic [4:0] S_U3    = 5'd7;  // prev[n]
	localparam logic [4:0] S_U4    = 5'd8;  // clear node links
	localparam logic [4:0] S_F0    = 5'd9;  // pair read
	localparam logic [4:0] S_F1    = 5'd10; // pair write
	localparam logic [4:0] S_P0    = 5'd11; // push: next[idx]=h
	localparam logic [4:0] S_P1    = 5'd12; // prev[h]=idx
	localparam logic [4:0] S_P2    = 5'd13; // prev[idx]=NIL
	localparam logic [4:0] S_P3    = 5'd14; // head=idx
	localparam logic [4:0] S_FREE  = 5'd15; // merge decision
	localparam logic [4:0] S_OUT   = 5'd16;
	localparam logic [4:0] S_PCLR  = 5'd17;
	localparam logic [4:0] S_P4    = 5'd18; // count up

	logic [4:0]       state_q;
	logic [AW-1:0]    clr_q;
	logic             func_q;
	logic [ORD_W:0]   rord_q;
	logic [ORD_W:0]   o_q;
	logic [IW-1:0]    cur_q, bud_q, p_q, n_q, h_q;
	logic             bit_q;
	rsp_t             rsp_q;
	logic             ovalid_q;

	logic [ORD_W:0]   rord;
	logic [PFN_W:0]   diff;
	logic [IW:0]      sz, even;
	logic [STAT_W-1:0] acc_st;
	logic             acc_done;

	assign rord = order_of(in_data.request_pages);
	assign diff = {1'b0, in_data.block_page} - {1'b0, base_page};
	assign sz = (IW+1)'(1) << o_q;
	assign even = ({1'b0, cur_q} >> (o_q + 1'b1)) << (o_q + 1'b1);

	assign in_ready = (state_q == S_IDLE) && !ovalid_q;
	assign out_valid = ovalid_q;
	assign out_data = rsp_q;
	assign ord = OW'(o_q);
	assign init_addr = clr_q;

	// immediate outcome of an accepted word
	always_comb begin
		acc_st = ST_OK;
		acc_done = 1'b0;
		if (in_data.func == FUNC_ALLOC) begin
			if (rord >= (ORD_W+1)'(ORDER_COUNT)) begin
				acc_st = ST_FAIL;
				acc_done = 1'b1;
			end
		end else if (in_data.is_null) begin
			acc_st = ST_FAIL;
			acc_done = 1'b1;
		end else if (diff[PFN_W] || in_data.block_page > last_page ||
				diff[PFN_W-1:0] >= PFN_W'(NUM_PAGES) ||
				rord >= (ORD_W+1)'(ORDER_COUNT)) begin
			acc_st = ST_RANGE;
			acc_done = 1'b1;
		end
	end

	always_comb begin
		op = OP_NONE;
		a_idx = cur_q;
		b_idx = NIL;
		case (state_q)
			S_CLR: op = OP_INIT;
			S_PCLR: op = OP_PINIT;
			S_U0: a_idx = bud_q;
			S_U2: begin
				if (p_q < NIL) begin
					op = OP_WNEXT;
					a_idx = p_q;
					b_idx = n_q;
				end else if (head_rd == bud_q) begin
					op = OP_HEAD;
					b_idx = n_q;
				end
			end
			S_U3: begin
				if (n_q < NIL) begin
					op = OP_WPREV;
					a_idx = n_q;
					b_idx = (p_q < NIL) ? p_q : NIL;
				end
			end
			S_U4: begin
				op = OP_WBOTH;
				a_idx = bud_q;
			end
			S_DECODE: op = OP_DEC;
			S_F0: op = OP_PAIRR;
			S_F1: begin
				op = OP_PAIRW;
			end
			S_P0: begin
				op = OP_WNEXT;
				b_idx = head_rd;
			end
			S_P1: begin
				if (h_q < NIL) begin
					op = OP_WPREV;
					a_idx = h_q;
					b_idx = cur_q;
				end
			end
			S_P2: begin
				op = OP_WPREV;
				b_idx = NIL;
			end
			S_P3: begin
				op = OP_HEAD;
				b_idx = cur_q;
			end
			S_P4: op = OP_INC;
			default: ;
		endcase
		if (state_q == S_F0 || state_q == S_F1)
			a_idx = IW'((cur_q >> (o_q + 1'b1)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			ovalid_q <= 1'b0;
			func_q   <= 1'b0;
			o_q      <= '0;
		end else begin
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					if (clr_q == AW'(NUM_PAGES - 1)) begin
						clr_q <= '0;
						state_q <= S_PCLR;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				// pair bits cleared one order at a time
				S_PCLR: begin
					if (clr_q == AW'(NUM_PAGES - 1)) begin
						clr_q <= '0;
						if (o_q == (ORD_W+1)'(ORDER_COUNT - 1)) begin
							o_q <= '0;
							state_q <= S_IDLE;
						end else begin
							o_q <= o_q + 1'b1;
						end
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (in_valid && in_ready) begin
						func_q <= in_data.func;
						rord_q <= rord;
						o_q <= rord;
						cur_q <= IW'(diff[PFN_W-1:0]);
						rsp_q <= '{status: acc_st, granted_page: '0, granted_order: '0};
						if (acc_done)
							state_q <= S_OUT;
						else if (in_data.func == FUNC_ALLOC)
							state_q <= S_SCAN;
						else
							state_q <= S_F0;
					end
				end
				S_SCAN: begin
					if (!lvl_empty) begin
						cur_q <= head_rd;
						bud_q <= head_rd;
						state_q <= S_U0;
					end else if (o_q + 1'b1 >= (ORD_W+1)'(ORDER_COUNT)) begin
						rsp_q.status <= ST_FAIL;
						state_q <= S_OUT;
					end else begin
						o_q <= o_q + 1'b1;
					end
				end
				S_U0: state_q <= S_U1;
				S_U1: begin
					p_q <= prev_rd;
					n_q <= next_rd;
					state_q <= S_U2;
				end
				S_U2: state_q <= S_U3;
				S_U3: state_q <= S_U4;
				S_U4: state_q <= S_DECODE;
				S_DECODE: begin
					// count down after unlink; a merge moves one order up
					if (func_q == FUNC_FREE) o_q <= o_q + 1'b1;
					state_q <= S_F0;
				end
				S_F0: state_q <= S_F1;
				S_F1: begin
					bit_q <= ~pair_rd;
					if (func_q == FUNC_ALLOC) begin
						if (o_q > rord_q) begin
							o_q <= o_q - 1'b1;
							state_q <= S_P0;
						end else begin
							rsp_q.granted_page <= base_page + PFN_W'(cur_q);
							rsp_q.granted_order <= ORD_W'(rord_q);
							state_q <= S_OUT;
						end
					end else begin
						state_q <= S_FREE;
					end
				end
				S_FREE: begin
					if (!bit_q && o_q + 1'b1 < (ORD_W+1)'(ORDER_COUNT) &&
							(({1'b0, cur_q} == even) ?
							({1'b0, cur_q} + sz < (IW+1)'(NUM_PAGES)) :
							({1'b0, cur_q} >= sz))) begin
						bud_q <= ({1'b0, cur_q} == even) ? IW'({1'b0, cur_q} + sz)
							: IW'({1'b0, cur_q} - sz);
						state_q <= S_U0;
					end else begin
						state_q <= S_P0;
					end
				end
				S_P0: begin
					h_q <= head_rd;
					state_q <= S_P1;
				end
				S_P1: state_q <= S_P2;
				S_P2: state_q <= S_P3;
				S_P3: state_q <= S_P4;
				S_P4: begin
					if (func_q == FUNC_ALLOC) begin
						cur_q <= IW'({1'b0, cur_q} + sz);
						state_q <= S_F0;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!ovalid_q) begin
						ovalid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_U4 && func_q == FUNC_FREE) begin
				if ({1'b0, bud_q} < {1'b0, cur_q}) cur_q <= bud_q;
			end
		end
	end

`ifndef ASSERT_OFF
	a_out_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> state_q == S_IDLE)
		else $error("result raised outside idle");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !ovalid_q)
		else $error("accepting with result pending");
	a_order_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_U0 |-> o_q < (ORD_W+1)'(ORDER_COUNT))
		else $error("order out of range");
`endif
endmodule

// ===== rtl/buddy_page_allocator_unit.sv =====
// Buddy page allocator top level: controller, datapath, config registers.
// Depends on bpa_pkg, bpa_if, bpa_ctrl, bpa_datapath.
// A new word is taken only once the result is accepted, in the cycle after the
// handshake. Splits and merges walk one level at a time through link-memory
// reads and writes.
// Reset: async, active low; then a clearing pass initializes link and pair
// memories before the first word is taken.
module buddy_page_allocator_unit #(
	parameter int NUM_PAGES   = bpa_pkg::NUM_PAGES_DEF,
	parameter int ORDER_COUNT = bpa_pkg::ORDER_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	bpa_req_if.sink   req,
	bpa_rsp_if.source rsp,
	bpa_cfg_if.sink   cfg
);
	import bpa_pkg::*;

	localparam int IW = $clog2(NUM_PAGES) + 1;
	localparam int AW = $clog2(NUM_PAGES);
	localparam int OW = (ORDER_COUNT > 1) ? $clog2(ORDER_COUNT) : 1;

	logic [PFN_W-1:0] base_q, last_q;
	logic [3:0]    op;
	logic [IW-1:0] a_idx, b_idx, next_rd, prev_rd, head_rd;
	logic [OW-1:0] ord;
	logic [AW-1:0] init_addr;
	logic          pair_rd, lvl_empty;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			last_q <= PFN_W'(4095);
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_BASE: base_q <= cfg.wdata;
				CFG_LAST: last_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	bpa_ctrl #(.NUM_PAGES(NUM_PAGES), .ORDER_COUNT(ORDER_COUNT)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
		.out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data),
		.base_page(base_q), .last_page(last_q),
		.op(op), .a_idx(a_idx), .b_idx(b_idx), .ord(ord), .init_addr(init_addr),
		.next_rd(next_rd), .prev_rd(prev_rd), .pair_rd(pair_rd),
		.head_rd(head_rd), .lvl_empty(lvl_empty));

	bpa_datapath #(.NUM_PAGES(NUM_PAGES), .ORDER_COUNT(ORDER_COUNT)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.op(op), .a_idx(a_idx), .b_idx(b_idx), .ord(ord), .init_addr(init_addr),
		.next_rd(next_rd), .prev_rd(prev_rd), .pair_rd(pair_rd),
		.head_rd(head_rd), .lvl_empty(lvl_empty));
endmodule
